### hdl/cpa_pkg.sv
// shared constants, angle table and stage payload type for the phase angle pipeline
package cpa_pkg;

  // cordic iteration count and the length of the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // datapath widths: inputs carry 8 guard bits, angle in units of 2^-16 rad
  localparam int IN_W    = 16;
  localparam int GUARD_W = 8;
  localparam int XW      = 28;
  localparam int ZW      = 21;
  localparam int OUT_W   = 16;

  localparam logic signed [ZW-1:0]    ANGLE_PI = ZW'(205887);
  localparam logic signed [OUT_W-1:0] PHASE_PI = OUT_W'(25736);
  localparam logic signed [ZW-1:0]    ROUND_HALF = ZW'(4);
  localparam int                      OUT_SHIFT  = 3;

  // round(atan(2^-i) * 65536)
  localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    ZW'(51472), ZW'(30386), ZW'(16055), ZW'(8150), ZW'(4091), ZW'(2047),
    ZW'(1024),  ZW'(512),   ZW'(256),   ZW'(128),  ZW'(64),   ZW'(32),
    ZW'(16),    ZW'(8),     ZW'(4),     ZW'(2),    ZW'(1),    ZW'(0),
    ZW'(0),     ZW'(0),     ZW'(0),     ZW'(0),    ZW'(0),    ZW'(0)
  };

  // payload carried from stage to stage
  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [ZW-1:0] z;
    logic          im_zero;
    logic          re_neg;
    logic          last;
  } cpa_vec_t;

endpackage

### hdl/cpa_prerot.sv
// input stage: guard scaling and quadrant pre-rotation
module cpa_prerot import cpa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  real_part,
  input  logic signed [IN_W-1:0]  imag_part,
  input  logic                    last_in,
  output logic                    vld,
  input  logic                    down_ready,
  output cpa_vec_t                dat
);

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic                 re_neg;
  logic                 im_pos;
  cpa_vec_t             dat_next;

  assign in_ready = !vld || down_ready;

  always_comb begin
    x_ext  = {{(XW-IN_W-GUARD_W){real_part[IN_W-1]}}, real_part, {GUARD_W{1'b0}}};
    y_ext  = {{(XW-IN_W-GUARD_W){imag_part[IN_W-1]}}, imag_part, {GUARD_W{1'b0}}};
    re_neg = real_part[IN_W-1];
    im_pos = !imag_part[IN_W-1] && (imag_part != '0);
    dat_next.im_zero = (imag_part == '0);
    dat_next.re_neg  = re_neg;
    dat_next.last    = last_in;
    if (re_neg) begin
      // turn by pi so the vector lies in the right half plane
      dat_next.x = -x_ext;
      dat_next.y = -y_ext;
      dat_next.z = im_pos ? ANGLE_PI : -ANGLE_PI;
    end else begin
      dat_next.x = x_ext;
      dat_next.y = y_ext;
      dat_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      dat <= dat_next;
    end
  end

endmodule

### hdl/cpa_cordic.sv
// unrolled cordic vectoring pipeline, one micro-rotation per stage
module cpa_cordic import cpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cpa_vec_t in_dat,
  output logic     out_valid,
  input  logic     out_ready,
  output cpa_vec_t out_dat
);

  logic     vld [STEPS+1];
  cpa_vec_t dat [STEPS+1];
  logic     go  [STEPS+1];

  assign vld[0]    = in_valid;
  assign dat[0]    = in_dat;
  assign in_ready  = go[1];
  assign out_valid = vld[STEPS];
  assign out_dat   = dat[STEPS];
  assign go[0]     = go[1];

  for (genvar k = 1; k <= STEPS; k++) begin : g_stage
    localparam int SH = k - 1;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    logic signed [ZW-1:0] zs;
    cpa_vec_t             dat_next;

    if (k == STEPS) begin : g_last
      assign go[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign go[k] = !vld[k] || go[k+1];
    end

    always_comb begin
      xs  = $signed(dat[k-1].x);
      ys  = $signed(dat[k-1].y);
      zs  = $signed(dat[k-1].z);
      xsh = xs >>> SH;
      ysh = ys >>> SH;
      dat_next = dat[k-1];
      // y at or above zero turns clockwise
      if (!ys[XW-1]) begin
        dat_next.x = xs + ysh;
        dat_next.y = ys - xsh;
        dat_next.z = zs + ATAN_TABLE[SH];
      end else begin
        dat_next.x = xs - ysh;
        dat_next.y = ys + xsh;
        dat_next.z = zs - ATAN_TABLE[SH];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (go[k]) begin
        dat[k] <= dat_next;
      end
    end
  end

endmodule

### hdl/cpa_round.sv
// output stage: rounding to q3.13, saturation and axis cases
module cpa_round import cpa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cpa_vec_t                in_dat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] phase,
  output logic                    last_out
);

  logic signed [ZW-1:0]    z_rnd;
  logic signed [ZW-1:0]    z_sh;
  logic signed [OUT_W-1:0] phase_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    z_rnd = $signed(in_dat.z) + ROUND_HALF;
    z_sh  = z_rnd >>> OUT_SHIFT;
    if (in_dat.im_zero) begin
      phase_next = in_dat.re_neg ? PHASE_PI : '0;
    end else if (z_sh > ZW'(PHASE_PI)) begin
      phase_next = PHASE_PI;
    end else if (z_sh < -ZW'(PHASE_PI)) begin
      phase_next = -PHASE_PI;
    end else begin
      phase_next = z_sh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      phase    <= phase_next;
      last_out <= in_dat.last;
    end
  end

endmodule

### hdl/complex_phase_angle.sv
// top level: phase angle atan2(imag, real) of one complex sample per transaction
// pipeline: pre-rotation register, one register per cordic micro-rotation, then the
//   rounding and saturation register
// throughput: one transaction per cycle while out_ready is high; every stage has its own valid
//   and its ready ripples back combinationally from out_ready, so bubbles are squeezed out on a stall
// reset: synchronous, active high; clears every stage valid, data registers keep state
module complex_phase_angle import cpa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  real_part,
  input  logic signed [IN_W-1:0]  imag_part,
  input  logic                    last_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] phase,
  output logic                    last_out
);

  // pre-rotation stage to cordic pipeline
  logic     pre_vld;
  logic     pre_rdy;
  cpa_vec_t pre_dat;

  // cordic pipeline to output stage
  logic     cor_vld;
  logic     cor_rdy;
  cpa_vec_t cor_dat;

  // scale by 256, fold the left half plane over by pi
  cpa_prerot u_prerot (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .real_part  (real_part),
    .imag_part  (imag_part),
    .last_in    (last_in),
    .vld        (pre_vld),
    .down_ready (pre_rdy),
    .dat        (pre_dat)
  );

  // vectoring iterations drive y towards zero and accumulate the angle in z
  cpa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_vld),
    .in_ready  (pre_rdy),
    .in_dat    (pre_dat),
    .out_valid (cor_vld),
    .out_ready (cor_rdy),
    .out_dat   (cor_dat)
  );

  // round half up to q3.13, clamp to +-pi, and settle the real axis exactly
  cpa_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_vld),
    .in_ready  (cor_rdy),
    .in_dat    (cor_dat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .phase     (phase),
    .last_out  (last_out)
  );

  // a delivered angle never leaves the closed range -pi..pi
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase <= PHASE_PI && phase >= -PHASE_PI))
    else $error("phase out of range");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !pre_vld && !cor_vld))
    else $error("valid after reset");

  // an empty input stage always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pre_vld |-> in_ready)
    else $error("input stalled while first stage empty");

  // a sample on the real axis comes out as zero or pi only
  a_axis_result: assert property (@(posedge clk) disable iff (rst)
    (cor_vld && cor_rdy && cor_dat.im_zero) |=>
      (phase == PHASE_PI || phase == '0))
    else $error("real axis sample gave an off-axis angle");

endmodule
